// ===== rtl/positional_insert_delete_stack_core_assert.svh =====
// Assertion macros shared by the stack core RTL.
`ifndef POSITIONAL_INSERT_DELETE_STACK_CORE_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_STACK_CORE_ASSERT_SVH

// Same-cycle implication, checked only while reset is released.
`define PIDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked only while reset is released.
`define PIDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/pids_pkg.sv =====
// Types, codes and defaults shared by the positional insert/delete stack.
package pids_pkg;

  localparam int DEPTH_DEF     = 128;
  localparam int WORD_BITS_DEF = 32;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 8;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    func_e                     func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_INS,
    S_PUT,
    S_GRAB,
    S_DN
  } state_e;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_TOP,
    CUR_POS,
    CUR_INC,
    CUR_DEC
  } cur_op_e;

  typedef enum logic [1:0] {
    RA_TOP,
    RA_POS,
    RA_CUR_INC,
    RA_CUR_DEC
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_CNT,
    WA_POS,
    WA_CUR_INC,
    WA_CUR_DEC
  } wr_sel_e;

  typedef enum logic {
    WD_VALUE,
    WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    RM_ZERO,
    RM_RDATA,
    RM_TAKE
  } rm_sel_e;

  typedef struct packed {
    logic    accept;
    cur_op_e cur_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    wd_sel_e wd_sel;
    cnt_op_e cnt_op;
    logic    take_en;
    logic    res_load;
    status_e res_status;
    rm_sel_e rm_sel;
  } cmd_t;

  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic ins_pos_ok;
    logic rem_pos_ok;
    logic ins_at_top;
    logic cur_at_pos;
    logic cur_at_top;
  } sts_t;

endpackage

// ===== rtl/positional_insert_delete_stack_core.sv =====
// Top level of the positional insert/delete stack: sequencer plus datapath.
//
//   Channel   Handshake                        Payload
//   command   start high while busy is low     item_i   (func, value, position)
//   result    done_o high for one cycle        result_o (status, removed_value, count)
//
// Push, insert at the top and every refused operation finish in the step that accepts
// them; pop reads the top word and loads the result in S_POP. Insert below the top and
// remove shift the entries from the position up in turn through the single write port.
// Each result is presented in the cycle after the last cycle of its command.
// Reset clears the fill count, the sequencer and the strobe; stored words stay undefined.
// The receiver cannot stall, and a new command may be accepted as a result is presented.
`include "positional_insert_delete_stack_core_assert.svh"

module positional_insert_delete_stack_core #(
  parameter int DEPTH     = pids_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pids_pkg::WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  pids_pkg::item_t   item_i,
  output logic              busy,
  output pids_pkg::result_t result_o,
  output logic              done_o
);

  import pids_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the handshake and decides each step from the datapath status.
  pids_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (item_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // The datapath holds the entries, the fill count and the registered result.
  pids_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .sts_o    (sts),
    .result_o (result_o),
    .done_o   (done_o)
  );

  // A result is only loaded on the step that returns the sequencer to idle.
  `PIDS_ASSERT_IMPL(a_done_when_idle, clk_i, rst_ni, done_o, !busy)
  // Every accepted transfer either completes next cycle or keeps the block busy.
  `PIDS_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  // A refused operation never hands back a word.
  `PIDS_ASSERT_IMPL(a_refused_zero, clk_i, rst_ni,
                    done_o && (result_o.status != ST_OK), result_o.removed_value == '0)

endmodule

// ===== rtl/pids_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pids_ctrl.sv =====
// Sequencer that turns each operation into RAM moves and a result load.
module pids_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  pids_pkg::func_e func_i,
  input  pids_pkg::sts_t  sts_i,
  output pids_pkg::cmd_t  cmd_o,
  output logic            busy
);

  import pids_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (func_i)
            FN_PUSH: state_d = S_IDLE;
            FN_POP: begin
              if (!sts_i.is_empty) state_d = S_POP;
            end
            FN_INSERT: begin
              if (!sts_i.is_full && sts_i.ins_pos_ok && !sts_i.ins_at_top) state_d = S_INS;
            end
            FN_REMOVE: begin
              if (!sts_i.is_empty && sts_i.rem_pos_ok) state_d = S_GRAB;
            end
          endcase
        end
      end
      S_POP: state_d = S_IDLE;
      S_INS: begin
        if (sts_i.cur_at_pos) state_d = S_PUT;
      end
      S_PUT: state_d = S_IDLE;
      S_GRAB: state_d = sts_i.cur_at_top ? S_IDLE : S_DN;
      S_DN: begin
        if (sts_i.cur_at_top) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.accept     = 1'b0;
    cmd_o.cur_op     = CUR_HOLD;
    cmd_o.rd_en      = 1'b0;
    cmd_o.rd_sel     = RA_TOP;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_sel     = WA_CNT;
    cmd_o.wd_sel     = WD_VALUE;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.take_en    = 1'b0;
    cmd_o.res_load   = 1'b0;
    cmd_o.res_status = ST_OK;
    cmd_o.rm_sel     = RM_ZERO;
    busy             = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          unique case (func_i)
            FN_PUSH: begin
              if (sts_i.is_full) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.wr_en    = 1'b1;
                cmd_o.wr_sel   = WA_CNT;
                cmd_o.cnt_op   = CNT_INC;
                cmd_o.res_load = 1'b1;
              end
            end
            FN_POP: begin
              if (sts_i.is_empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_TOP;
              end
            end
            FN_INSERT: begin
              priority if (sts_i.is_full) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_FULL;
              end else if (!sts_i.ins_pos_ok) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_BADPOS;
              end else if (sts_i.ins_at_top) begin
                cmd_o.wr_en    = 1'b1;
                cmd_o.wr_sel   = WA_POS;
                cmd_o.cnt_op   = CNT_INC;
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_TOP;
                cmd_o.cur_op = CUR_TOP;
              end
            end
            FN_REMOVE: begin
              priority if (sts_i.is_empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else if (!sts_i.rem_pos_ok) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_BADPOS;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_POS;
                cmd_o.cur_op = CUR_POS;
              end
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.cnt_op   = CNT_DEC;
        cmd_o.res_load = 1'b1;
        cmd_o.rm_sel   = RM_RDATA;
      end
      S_INS: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_CUR_INC;
        cmd_o.wd_sel = WD_RDATA;
        if (!sts_i.cur_at_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_CUR_DEC;
          cmd_o.cur_op = CUR_DEC;
        end
      end
      S_PUT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WA_POS;
        cmd_o.cnt_op   = CNT_INC;
        cmd_o.res_load = 1'b1;
      end
      S_GRAB: begin
        cmd_o.take_en = 1'b1;
        if (sts_i.cur_at_top) begin
          cmd_o.cnt_op   = CNT_DEC;
          cmd_o.res_load = 1'b1;
          cmd_o.rm_sel   = RM_RDATA;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_CUR_INC;
          cmd_o.cur_op = CUR_INC;
        end
      end
      S_DN: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_CUR_DEC;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.cur_at_top) begin
          cmd_o.cnt_op   = CNT_DEC;
          cmd_o.res_load = 1'b1;
          cmd_o.rm_sel   = RM_TAKE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_CUR_INC;
          cmd_o.cur_op = CUR_INC;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/pids_dp.sv =====
// Datapath: fill count, move cursor, entry RAM and result register.
module pids_dp #(
  parameter int DEPTH     = pids_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pids_pkg::WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pids_pkg::cmd_t    cmd_i,
  input  pids_pkg::item_t   item_i,
  output pids_pkg::sts_t    sts_o,
  output pids_pkg::result_t result_o,
  output logic              done_o
);

  import pids_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  item_t          item_q, cur_item;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  cur_q, cur_d;
  logic [AW-1:0]  top_idx, pos_idx, cnt_idx;
  logic [PW-1:0]  pos_x, cnt_x, pos_m1;
  logic [CW-1:0]  cnt_m1;
  logic [WORD_BITS-1:0] value_w, rdata, take_q, wdata;
  logic [VALUE_W-1:0]   rdata_ext, take_ext;
  logic [COUNT_W-1:0]   count_out;
  logic [AW-1:0]  raddr, waddr;
  result_t        result_q, result_d;
  logic           done_q;

  assign cur_item = cmd_i.accept ? item_i : item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= item_i;
    end
    if (cmd_i.take_en) begin
      take_q <= rdata;
    end
    if (cmd_i.res_load) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // Index arithmetic; positions are 1-based on the port.
  assign pos_x   = PW'(cur_item.position);
  assign cnt_x   = PW'(cnt_q);
  assign pos_m1  = pos_x - PW'(1);
  assign pos_idx = pos_m1[AW-1:0];
  assign cnt_m1  = cnt_q - CW'(1);
  assign top_idx = cnt_m1[AW-1:0];
  assign cnt_idx = cnt_q[AW-1:0];

  assign sts_o.is_empty   = (cnt_q == '0);
  assign sts_o.is_full    = (cnt_q == CW'(DEPTH));
  assign sts_o.ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1));
  assign sts_o.rem_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign sts_o.ins_at_top = (pos_m1 == cnt_x);
  assign sts_o.cur_at_pos = (cur_q == pos_idx);
  assign sts_o.cur_at_top = (cur_q == top_idx);

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_m1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cur_op)
      CUR_TOP: cur_d = top_idx;
      CUR_POS: cur_d = pos_idx;
      CUR_INC: cur_d = cur_q + AW'(1);
      CUR_DEC: cur_d = cur_q - AW'(1);
      default: cur_d = cur_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RA_TOP:     raddr = top_idx;
      RA_POS:     raddr = pos_idx;
      RA_CUR_INC: raddr = cur_q + AW'(1);
      RA_CUR_DEC: raddr = cur_q - AW'(1);
      default:    raddr = top_idx;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WA_CNT:     waddr = cnt_idx;
      WA_POS:     waddr = pos_idx;
      WA_CUR_INC: waddr = cur_q + AW'(1);
      WA_CUR_DEC: waddr = cur_q - AW'(1);
      default:    waddr = cnt_idx;
    endcase
  end

  assign wdata = (cmd_i.wd_sel == WD_RDATA) ? rdata : value_w;

  // Word width adaptation between the 32-bit port fields and storage.
  if (WORD_BITS < VALUE_W) begin : g_narrow
    assign value_w   = cur_item.value[WORD_BITS-1:0];
    assign rdata_ext = {{(VALUE_W - WORD_BITS){rdata[WORD_BITS-1]}}, rdata};
    assign take_ext  = {{(VALUE_W - WORD_BITS){take_q[WORD_BITS-1]}}, take_q};
  end else if (WORD_BITS == VALUE_W) begin : g_equal
    assign value_w   = cur_item.value;
    assign rdata_ext = rdata;
    assign take_ext  = take_q;
  end else begin : g_wide
    assign value_w   = {{(WORD_BITS - VALUE_W){1'b0}}, cur_item.value};
    assign rdata_ext = rdata[VALUE_W-1:0];
    assign take_ext  = take_q[VALUE_W-1:0];
  end

  if (CW < COUNT_W) begin : g_cnt_pad
    assign count_out = {{(COUNT_W - CW){1'b0}}, cnt_d};
  end else begin : g_cnt_cut
    assign count_out = cnt_d[COUNT_W-1:0];
  end

  always_comb begin
    result_d.status = cmd_i.res_status;
    result_d.count  = count_out;
    unique case (cmd_i.rm_sel)
      RM_RDATA: result_d.removed_value = rdata_ext;
      RM_TAKE:  result_d.removed_value = take_ext;
      default:  result_d.removed_value = '0;
    endcase
  end

  pids_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

// ===== bench/positional_insert_delete_stack_core_test.sv =====
// Self-checking testbench for the positional insert/delete stack core.
module positional_insert_delete_stack_core_test;
  import pids_pkg::*;

  // The core is built with its default depth and word width, so the predictor
  // keeps a shadow stack of the same size.
  localparam int STACK_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_OPS    = 1350;
  // The slowest correct run is about 1400 commands, each an insert at the bottom
  // of a nearly full stack followed by the longest idle gap. The limit is several
  // times that.
  localparam int CYCLE_LIMIT   = 1_500_000;
  // The longest operation is an insert at position 1 of a 127 entry stack, so the
  // settling time is sized from the stack depth.
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 16;

  // A command waiting to be sent, with the idle cycles that precede it and a
  // flag that makes the sender wait until every result is back.
  typedef struct {
    item_t       cmd;
    int unsigned gap;
    bit          drain_first;
  } pending_op_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  result_t result_o;
  logic    done_o;

  positional_insert_delete_stack_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .result_o (result_o),
    .done_o   (done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the stack contents and fill level.
  logic signed [VALUE_W-1:0] shadow_words [STACK_DEPTH];
  int                        shadow_fill = 0;

  result_t     expected_results [$];
  pending_op_t pending_ops [$];

  int gen_fill       = 0;  // fill level as seen by the stimulus generator
  int in_flight      = 0;  // commands accepted whose result has not come back
  int mismatch_count = 0;
  int cycle_count    = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Applies one command to the shadow stack and returns the result the core
  // must produce for it. Refused commands leave the stack untouched and return
  // a zero word.
  function automatic result_t apply_stack_op(item_t op);
    result_t res;
    int      pos;
    int      i;
    res.status        = ST_OK;
    res.removed_value = '0;
    pos               = int'(op.position);
    case (op.func)
      FN_PUSH: begin
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = op.value;
          shadow_fill++;
        end
      end
      FN_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_fill--;
          res.removed_value = shadow_words[shadow_fill];
        end
      end
      FN_INSERT: begin
        // A full stack is reported as full before the position is looked at.
        if (shadow_fill >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else if (pos == 0 || pos > shadow_fill + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = shadow_fill; i >= pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos-1] = op.value;
          shadow_fill++;
        end
      end
      default: begin
        // Remove: an empty stack is reported before the position is looked at.
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (pos == 0 || pos > shadow_fill) begin
          res.status = ST_BADPOS;
        end else begin
          res.removed_value = shadow_words[pos-1];
          for (i = pos; i < shadow_fill; i++) shadow_words[i-1] = shadow_words[i];
          shadow_fill--;
        end
      end
    endcase
    res.count = COUNT_W'(shadow_fill);
    return res;
  endfunction

  // Queues a command and tracks the fill level it leaves behind, so that the
  // generator can aim positions at the current stack.
  function automatic void add_op(func_e f, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p,
                                 int unsigned gap, bit drain_first);
    pending_op_t op;
    op.cmd.func     = f;
    op.cmd.value    = v;
    op.cmd.position = p;
    op.gap          = gap;
    op.drain_first  = drain_first;
    pending_ops.push_back(op);
    case (f)
      FN_PUSH:   if (gen_fill < STACK_DEPTH) gen_fill++;
      FN_POP:    if (gen_fill > 0) gen_fill--;
      FN_INSERT: if (gen_fill < STACK_DEPTH && p != 0 && p <= gen_fill + 1) gen_fill++;
      default:   if (gen_fill > 0 && p != 0 && p <= gen_fill) gen_fill--;
    endcase
  endfunction

  // Zero half the time, often short, now and then long.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Words are mostly random, with the two's complement extremes mixed in.
  function automatic logic [VALUE_W-1:0] pick_word();
    if ($urandom_range(0, 99) >= 12) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Positions are mostly legal for the current fill level. The rest are the
  // two ends, zero, one past the last legal slot, or anything up to 255.
  function automatic logic [POS_W-1:0] pick_position(int fill, bit for_insert);
    int top;
    int r;
    top = for_insert ? fill + 1 : fill;
    r   = $urandom_range(0, 99);
    if (r < 65) return POS_W'((top >= 1) ? $urandom_range(1, top) : 1);
    if (r < 75) return POS_W'((r % 2 == 0 || top < 1) ? 1 : top);
    if (r < 85) return '0;
    if (r < 92) return POS_W'(top + 1);
    return POS_W'($urandom_range(top + 1, 255));
  endfunction

  function automatic func_e pick_func(int w_push, int w_pop, int w_ins);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_push) return FN_PUSH;
    if (r < w_push + w_pop) return FN_POP;
    if (r < w_push + w_pop + w_ins) return FN_INSERT;
    return FN_REMOVE;
  endfunction

  function automatic void add_random(int w_push, int w_pop, int w_ins, bit quiet,
                                     bit drain_first);
    func_e            f;
    logic [POS_W-1:0] p;
    f = pick_func(w_push, w_pop, w_ins);
    if (f == FN_INSERT) p = pick_position(gen_fill, 1'b1);
    else if (f == FN_REMOVE) p = pick_position(gen_fill, 1'b0);
    else p = POS_W'($urandom_range(0, 255));  // ignored by push and pop, but still driven
    add_op(f, pick_word(), p, pick_gap(quiet), drain_first);
  endfunction

  // Command driver. A command is offered with start high and stays on the
  // ports until the core takes it, which happens at a rising edge where busy
  // is low. The transfer is predicted right there, so the expectation is queued
  // before the core can return its result. The driver also counts outstanding
  // commands itself from sampled handshakes, which gives an exact point at
  // which the core has nothing left in hand.
  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    bit took;
    int outstanding;
    if (!rst_ni) begin
      start     <= 1'b0;
      item_i    <= '0;
      in_flight <= 0;
    end else begin
      took        = start && !busy;
      outstanding = in_flight;
      if (took) begin
        expected_results.push_back(apply_stack_op(item_i));
        outstanding++;
      end
      if (done_o) outstanding--;
      in_flight <= outstanding;
      // A command not yet taken simply stays on the ports.
      if (!start || took) begin
        if (pending_ops.size() == 0) begin
          start <= 1'b0;
        end else if (pending_ops[0].gap > 0) begin
          start              <= 1'b0;
          pending_ops[0].gap = pending_ops[0].gap - 1;
        end else if (pending_ops[0].drain_first && outstanding != 0) begin
          start <= 1'b0;
        end else begin
          item_i <= pending_ops[0].cmd;
          start  <= 1'b1;
          void'(pending_ops.pop_front());
        end
      end
    end
  end

  // Result monitor. Every result is a one-cycle transfer marked by done_o and
  // is compared field by field with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no command outstanding: status %0d count %0d",
                                  result_o.status, result_o.count));
      end else begin
        want = expected_results.pop_front();
        if (result_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result_o.status, want.status));
        if (result_o.removed_value !== want.removed_value)
          report_mismatch($sformatf("removed word %0d, expected %0d",
                                    result_o.removed_value, want.removed_value));
        if (result_o.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", result_o.count, want.count));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int  total_ops;
    int  n;
    int  kind;
    bit  quiet;
    bit  hold_next;
    bit  first_phase;

    // Directed part. It starts with refusals on an empty stack, builds a small
    // stack from the word extremes, inserts at the top and in the middle,
    // tries bad positions including zero and 255, removes from the middle,
    // the bottom and the top, and then pops down to empty and once more.
    add_op(FN_POP,    32'h0,         8'd0,   0,           1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd1,   0,           1'b0);
    add_op(FN_INSERT, 32'h1234_5678, 8'd0,   pick_gap(0), 1'b0);
    add_op(FN_INSERT, 32'h1234_5678, 8'd2,   0,           1'b0);
    add_op(FN_INSERT, 32'h7FFF_FFFF, 8'd1,   pick_gap(0), 1'b0);
    add_op(FN_PUSH,   32'h8000_0000, 8'd255, 0,           1'b1);
    add_op(FN_PUSH,   32'hFFFF_FFFF, 8'd0,   0,           1'b0);
    add_op(FN_PUSH,   32'h0000_0000, 8'd128, pick_gap(0), 1'b0);
    add_op(FN_INSERT, 32'h5555_5555, 8'd5,   0,           1'b0);
    add_op(FN_INSERT, 32'h0BAD_0BAD, 8'd7,   0,           1'b0);
    add_op(FN_INSERT, 32'h0BAD_0BAD, 8'd255, pick_gap(0), 1'b0);
    add_op(FN_INSERT, 32'hAAAA_AAAA, 8'd3,   0,           1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd0,   0,           1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd7,   pick_gap(0), 1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd255, 0,           1'b0);
    add_op(FN_REMOVE, 32'hFFFF_FFFF, 8'd3,   0,           1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd1,   pick_gap(0), 1'b0);
    add_op(FN_REMOVE, 32'h0,         8'd4,   0,           1'b0);
    add_op(FN_POP,    32'hFFFF_FFFF, 8'd255, 0,           1'b0);
    add_op(FN_POP,    32'h0,         8'd0,   pick_gap(0), 1'b0);
    add_op(FN_POP,    32'h0,         8'd0,   0,           1'b0);
    add_op(FN_POP,    32'h0,         8'd0,   0,           1'b0);

    // Random part, in phases. Fill phases mostly push and insert until the
    // stack is full and then keep knocking on it; drain phases mostly pop and
    // remove until it is empty and then keep asking; mixed phases wander.
    // Some phases run with no idle cycles at all, and the first random phase
    // opens by waiting until every result is back.
    total_ops   = pending_ops.size() + RANDOM_OPS;
    first_phase = 1'b1;
    while (pending_ops.size() < total_ops) begin
      kind        = $urandom_range(0, 2);
      quiet       = ($urandom_range(0, 3) == 0);
      hold_next   = first_phase || ($urandom_range(0, 2) == 0);
      first_phase = 1'b0;
      case (kind)
        0: begin
          for (n = 0; gen_fill < STACK_DEPTH && n < 400 &&
                      pending_ops.size() < total_ops; n++) begin
            add_random(40, 5, 45, quiet, hold_next);
            hold_next = 1'b0;
          end
          repeat ($urandom_range(3, 10)) add_random(45, 5, 45, quiet, 1'b0);
        end
        1: begin
          for (n = 0; gen_fill > 0 && n < 400 &&
                      pending_ops.size() < total_ops; n++) begin
            add_random(5, 40, 10, quiet, hold_next);
            hold_next = 1'b0;
          end
          repeat ($urandom_range(3, 10)) add_random(5, 45, 5, quiet, 1'b0);
        end
        default: begin
          repeat ($urandom_range(20, 80)) begin
            add_random(25, 25, 25, quiet, hold_next);
            hold_next = 1'b0;
          end
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Everything is sampled at the falling edge, where all handshake state is
    // settled.
    do @(negedge clk_i);
    while (pending_ops.size() > 0 || start || in_flight != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pids_pkg.sv
rtl/pids_ram.sv
rtl/pids_ctrl.sv
rtl/pids_dp.sv
rtl/positional_insert_delete_stack_core.sv
bench/positional_insert_delete_stack_core_test.sv
